// File: hw/rtl/edf_pkg.sv
// edf_pkg: shared types and constants of the escaped frame deframer
// no dependencies; used by every rtl file of the block and by its checker
`default_nettype none

package edf_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_END        = 2'd1,
    KIND_BAD_ESCAPE = 2'd2,
    KIND_TOO_LONG   = 2'd3
  } kind_e;

  // framing modes
  localparam logic [1:0] MODE_HUNT   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_INSIDE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_FLAG_BYTE       = 3'd0;
  localparam logic [2:0] REG_ESCAPE_BYTE     = 3'd1;
  localparam logic [2:0] REG_CODE_FOR_FLAG   = 3'd2;
  localparam logic [2:0] REG_CODE_FOR_ESCAPE = 3'd3;
  localparam logic [2:0] REG_MAX_FRAME_LEN   = 3'd4;

  // configuration reset values
  localparam logic [7:0]  RST_FLAG_BYTE       = 8'd126;
  localparam logic [7:0]  RST_ESCAPE_BYTE     = 8'd125;
  localparam logic [7:0]  RST_CODE_FOR_FLAG   = 8'd2;
  localparam logic [7:0]  RST_CODE_FOR_ESCAPE = 8'd1;
  localparam logic [15:0] RST_MAX_FRAME_LEN   = 16'd1024;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  code_for_flag;
    logic [7:0]  code_for_escape;
    logic [15:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] frame_len;
    logic        last;
  } result_t;

  // up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/edf_decode.sv
// edf_decode: framing state registers and per-byte decode logic
// depends on edf_pkg (cfg_t, push_t, mode and kind codes)
`default_nettype none

module edf_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire edf_pkg::cfg_t cfg_i,
  output edf_pkg::push_t     push_o
);

  logic [1:0]  mode_q, mode_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  prev_q, prev_d;
  logic        body;
  logic [7:0]  dec_byte;
  edf_pkg::push_t push;

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    prev_d   = prev_q;
    push     = '0;
    body     = 1'b0;
    dec_byte = (in_byte_i == cfg_i.code_for_flag) ? cfg_i.flag_byte : cfg_i.escape_byte;

    if (!accept_i) begin
      push = '0;
    end else if (mode_q != edf_pkg::MODE_START && mode_q != edf_pkg::MODE_INSIDE) begin
      // hunting: wait for an opening flag
      if (in_byte_i == cfg_i.flag_byte) begin
        mode_d  = edf_pkg::MODE_START;
        count_d = '0;
        prev_d  = '0;
      end
    end else if (in_byte_i == cfg_i.flag_byte) begin
      // leading flags are skipped, a later one closes the frame
      if (count_q != '0) begin
        push.num          = 2'd1;
        push.r0.kind      = edf_pkg::KIND_END;
        push.r0.frame_len = count_q;
        mode_d            = edf_pkg::MODE_HUNT;
        count_d           = '0;
        prev_d            = '0;
      end
    end else if (prev_q == cfg_i.escape_byte) begin
      // second byte of an escape pair
      if (in_byte_i == cfg_i.code_for_flag || in_byte_i == cfg_i.code_for_escape) begin
        push.num         = 2'd1;
        push.r0.kind     = edf_pkg::KIND_DATA;
        push.r0.out_byte = dec_byte;
        prev_d           = in_byte_i;
        body             = 1'b1;
      end else begin
        push.num     = 2'd1;
        push.r0.kind = edf_pkg::KIND_BAD_ESCAPE;
        mode_d       = edf_pkg::MODE_HUNT;
        count_d      = '0;
        prev_d       = '0;
      end
    end else begin
      // plain byte or start of an escape pair, both counted
      if (in_byte_i != cfg_i.escape_byte) begin
        push.num         = 2'd1;
        push.r0.kind     = edf_pkg::KIND_DATA;
        push.r0.out_byte = in_byte_i;
      end
      count_d = count_q + 16'd1;
      prev_d  = in_byte_i;
      body    = 1'b1;
    end

    if (body) begin
      if (count_d != '0) begin
        mode_d = edf_pkg::MODE_INSIDE;
      end
      if (count_d >= cfg_i.max_frame_len) begin
        if (push.num == 2'd0) begin
          push.r0.kind = edf_pkg::KIND_TOO_LONG;
        end else begin
          push.r1.kind = edf_pkg::KIND_TOO_LONG;
        end
        push.num = push.num + 2'd1;
        mode_d   = edf_pkg::MODE_HUNT;
        count_d  = '0;
        prev_d   = '0;
      end
    end

    // mark the final result of this byte
    if (push.num == 2'd1) begin
      push.r0.last = 1'b1;
    end else if (push.num == 2'd2) begin
      push.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= edf_pkg::MODE_HUNT;
      count_q <= '0;
      prev_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      prev_q  <= prev_d;
    end
  end

  assign push_o = push;

endmodule

`default_nettype wire

// File: hw/rtl/edf_result_queue.sv
// edf_result_queue: four-entry result queue, up to two pushes and one pop a cycle
// depends on edf_pkg (push_t, result_t)
`default_nettype none

module edf_result_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire edf_pkg::push_t push_i,
  input  wire logic           pop_i,
  output logic                room_o,
  output logic                valid_o,
  output edf_pkg::result_t    head_o
);

  edf_pkg::result_t entry_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign do_pop  = pop_i && (cnt_q != 3'd0);
  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.num;
      rd_ptr_q <= rd_ptr_q + {1'b0, do_pop};
      cnt_q    <= cnt_q + {1'b0, push_i.num} - {2'b00, do_pop};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/escaped_frame_deframer.sv
// escaped_frame_deframer: top level, configuration registers and channel glue
// depends on edf_pkg, edf_decode and edf_result_queue
//
// Usage:
//  - input channel (in_valid_i / in_ready_o / in_byte_i) takes one raw line byte
//    per transaction; output channel (out_valid_o / out_ready_i) delivers one
//    result per transaction: decoded byte, frame end with length, or a drop
//  - a byte causes zero, one or two results; last_o marks the final one of a byte
//  - the results of a byte are registered in the result queue before they reach
//    the output
//  - throughput: one byte per cycle while each byte gives at most one result and
//    the receiver is ready; the result queue is four deep and holds off input
//    (in_ready_o low) when it holds more than two results; a byte with two
//    results needs two output transactions, and the output takes one per cycle
//  - a stalled receiver fills the queue and then stops input; nothing is lost
//  - configuration: write transactions on cfg_valid_i / cfg_ready_o, always
//    ready; indexes beyond the register list are ignored; write only while idle
//  - reset: registers take their default values, the framer hunts for a flag,
//    the result queue is empty
`default_nettype none

module escaped_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      frame_len_o,
  output logic             last_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  edf_pkg::cfg_t    cfg_q;
  edf_pkg::push_t   push;
  edf_pkg::result_t head;
  logic             accept;
  logic             room;

  // configuration register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte       <= edf_pkg::RST_FLAG_BYTE;
      cfg_q.escape_byte     <= edf_pkg::RST_ESCAPE_BYTE;
      cfg_q.code_for_flag   <= edf_pkg::RST_CODE_FOR_FLAG;
      cfg_q.code_for_escape <= edf_pkg::RST_CODE_FOR_ESCAPE;
      cfg_q.max_frame_len   <= edf_pkg::RST_MAX_FRAME_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        edf_pkg::REG_FLAG_BYTE:       cfg_q.flag_byte       <= cfg_data_i[7:0];
        edf_pkg::REG_ESCAPE_BYTE:     cfg_q.escape_byte     <= cfg_data_i[7:0];
        edf_pkg::REG_CODE_FOR_FLAG:   cfg_q.code_for_flag   <= cfg_data_i[7:0];
        edf_pkg::REG_CODE_FOR_ESCAPE: cfg_q.code_for_escape <= cfg_data_i[7:0];
        edf_pkg::REG_MAX_FRAME_LEN:   cfg_q.max_frame_len   <= cfg_data_i;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // input transaction only when the queue can take two more results
  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  edf_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .cfg_i     (cfg_q),
    .push_o    (push)
  );

  edf_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // result fields straight from the queue head register
  assign kind_o      = head.kind;
  assign out_byte_o  = head.out_byte;
  assign frame_len_o = head.frame_len;
  assign last_o      = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/edf_checker.sv
// edf_checker: port-level assertions for escaped_frame_deframer, bound to the top
// depends on edf_pkg (kind codes)
`default_nettype none

module edf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  kind_i,
  input wire logic [7:0]  out_byte_i,
  input wire logic [15:0] frame_len_i,
  input wire logic        last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(out_byte_i) && $stable(frame_len_i) && $stable(last_i))
    else $error("stalled result changed");

  // fields that do not belong to the kind read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == edf_pkg::KIND_DATA || out_byte_i == 8'd0) &&
      (kind_i == edf_pkg::KIND_END || frame_len_i == 16'd0))
    else $error("unused result field not zero");

  // frame end and drops always close the results of their byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != edf_pkg::KIND_DATA |-> last_i)
    else $error("non-data result without last");

  // a reported frame is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == edf_pkg::KIND_END |-> frame_len_i != 16'd0)
    else $error("frame end with zero length");

endmodule

bind escaped_frame_deframer edf_checker u_edf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_i      (kind_o),
  .out_byte_i  (out_byte_o),
  .frame_len_i (frame_len_o),
  .last_i      (last_o)
);

`default_nettype wire
